// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds in every cycle out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ps2fr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ps2fr_pkg;

    // event kinds on the input stream
    localparam logic [1:0] KIND_CLOCK = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // frame status codes on the result stream
    localparam logic [2:0] STAT_NONE      = 3'd0;
    localparam logic [2:0] STAT_STORED    = 3'd1;
    localparam logic [2:0] STAT_PARITY    = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_START_ERR = 3'd4;

    // frame layout: start, 8 data, parity, stop
    localparam logic [3:0]  BIT_LAST      = 4'd10;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    // request from the frame front end to the buffer back end
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_PARITY_ERR,
        OP_START_ERR,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/ps2fr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ps2fr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [1:0]        kind,
    input  wire logic              data_bit,
    input  wire logic [15:0]       idle_timeout,
    output ps2fr_pkg::cmd_t        cmd
);

    logic [3:0]  pos_reg,    pos_next;
    logic [10:0] shift_reg,  shift_next;
    logic        par_reg,    par_next;
    logic [15:0] timer_reg,  timer_next;

    logic [3:0]  pos_eff;
    logic [10:0] shift_eff;
    logic        par_eff;
    logic        timed_out;
    logic        par_final;

    // abandon a stale partial frame before taking the bit
    assign timed_out = (pos_reg != 4'd0) && (timer_reg > idle_timeout);
    assign pos_eff   = timed_out ? 4'd0  : pos_reg;
    assign shift_eff = timed_out ? 11'd0 : shift_reg;
    assign par_eff   = timed_out ? 1'b0  : par_reg;

    // stop bit counted and then removed again
    assign par_final = par_eff ^ data_bit ^ 1'b1;

    // classify the event and advance the frame state
    always_comb
    begin
        pos_next   = pos_reg;
        shift_next = shift_reg;
        par_next   = par_reg;
        timer_next = timer_reg;
        cmd.op     = ps2fr_pkg::OP_NONE;
        cmd.data   = shift_eff[8:1];
        case (kind)
            ps2fr_pkg::KIND_CLOCK:
            begin
                if (pos_eff == ps2fr_pkg::BIT_LAST)
                begin
                    cmd.op     = par_final ? ps2fr_pkg::OP_PUSH : ps2fr_pkg::OP_PARITY_ERR;
                    pos_next   = 4'd0;
                    shift_next = 11'd0;
                    par_next   = 1'b0;
                end
                else if ((pos_eff == 4'd0) && data_bit)
                begin
                    cmd.op     = ps2fr_pkg::OP_START_ERR;
                    pos_next   = 4'd0;
                    shift_next = 11'd0;
                    par_next   = 1'b0;
                end
                else
                begin
                    shift_next          = shift_eff;
                    shift_next[pos_eff] = shift_eff[pos_eff] | data_bit;
                    par_next            = par_eff ^ data_bit;
                    pos_next            = pos_eff + 4'd1;
                    timer_next          = 16'd0;
                end
            end
            ps2fr_pkg::KIND_TICK:
            begin
                if (timer_reg != ps2fr_pkg::TIMER_MAX)
                begin
                    timer_next = timer_reg + 16'd1;
                end
            end
            ps2fr_pkg::KIND_READ:
            begin
                cmd.op = ps2fr_pkg::OP_READ;
            end
            ps2fr_pkg::KIND_CLEAR:
            begin
                cmd.op = ps2fr_pkg::OP_CLEAR;
            end
            default:
            begin
                cmd.op = ps2fr_pkg::OP_NONE;
            end
        endcase
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            shift_reg <= 11'd0;
            par_reg   <= 1'b0;
            timer_reg <= 16'd0;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            par_reg   <= par_next;
            timer_reg <= timer_next;
        end
    end

    `ASSERT_ALWAYS(a_pos_range, pos_reg <= ps2fr_pkg::BIT_LAST, "bit position past stop bit")
    `ASSERT_NEXT(a_idle_frame_clear, pos_reg == 4'd0, shift_reg == 11'd0 || pos_reg != 4'd0,
        "frame bits left while awaiting start")

endmodule

`default_nettype wire

// ===== sv/ps2fr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ps2fr_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ps2fr_pkg::cmd_t   push_cmd,
    output logic                   ready,
    input  wire logic              pop,
    output logic                   valid,
    output ps2fr_pkg::cmd_t        pop_cmd
);

    ps2fr_pkg::cmd_t entry_reg [2];
    logic       wr_idx_reg, wr_idx_next;
    logic       rd_idx_reg, rd_idx_next;
    logic [1:0] count_reg,  count_next;

    assign ready   = (count_reg != 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign pop_cmd = entry_reg[rd_idx_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_idx_next = push ? ~wr_idx_reg : wr_idx_reg;
        rd_idx_next = pop  ? ~rd_idx_reg : rd_idx_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_idx_reg] <= push_cmd;
        end
    end

    `ASSERT_ALWAYS(a_count_range, count_reg != 2'd3, "queue count overflow")
    `ASSERT_ALWAYS(a_ptr_match, (count_reg == 2'd1) == (wr_idx_reg != rd_idx_reg),
        "queue pointers disagree with count")

endmodule

`default_nettype wire

// ===== sv/ps2fr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ps2fr_back #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire ps2fr_pkg::cmd_t   cmd,
    output logic                   cmd_pop,
    output logic [7:0]             read_data,
    output logic                   read_valid,
    output logic [3:0]             fill_count,
    output logic [2:0]             frame_status,
    output logic                   out_valid,
    input  wire logic              out_ready
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int FW = PW + 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(BUFFER_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(BUFFER_DEPTH - 1);
    localparam logic [FW-1:0] DEPTH_W  = FW'(BUFFER_DEPTH);

    logic [7:0] mem [BUFFER_DEPTH];

    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    data_reg;
    logic          rvalid_reg;
    logic [3:0]    fill_reg;
    logic [2:0]    status_reg;

    logic          take;
    logic          do_write;
    logic          do_pop;
    logic [FW-1:0] fill_cur;
    logic [FW-1:0] fill_next;
    logic [2:0]    status_next;

    // ring buffer occupancy
    function automatic logic [FW-1:0] fill_of(input logic [PW-1:0] w, input logic [PW-1:0] r);
        logic [FW-1:0] wx;
        logic [FW-1:0] rx;
        wx = {1'b0, w};
        rx = {1'b0, r};
        fill_of = (w >= r) ? (wx - rx) : (DEPTH_W - rx + wx);
    endfunction

    assign take     = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_pop  = take;
    assign fill_cur = fill_of(wp_reg, rp_reg);

    // carry out one request against the buffer
    always_comb
    begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        do_write    = 1'b0;
        do_pop      = 1'b0;
        status_next = ps2fr_pkg::STAT_NONE;
        case (cmd.op)
            ps2fr_pkg::OP_PUSH:
            begin
                if (fill_cur < FILL_MAX)
                begin
                    do_write    = 1'b1;
                    wp_next     = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                    status_next = ps2fr_pkg::STAT_STORED;
                end
                else
                begin
                    status_next = ps2fr_pkg::STAT_FULL;
                end
            end
            ps2fr_pkg::OP_PARITY_ERR:
            begin
                status_next = ps2fr_pkg::STAT_PARITY;
            end
            ps2fr_pkg::OP_START_ERR:
            begin
                status_next = ps2fr_pkg::STAT_START_ERR;
            end
            ps2fr_pkg::OP_READ:
            begin
                if (wp_reg != rp_reg)
                begin
                    do_pop  = 1'b1;
                    rp_next = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
                end
            end
            ps2fr_pkg::OP_CLEAR:
            begin
                wp_next = '0;
                rp_next = '0;
            end
            default:
            begin
                status_next = ps2fr_pkg::STAT_NONE;
            end
        endcase
        fill_next = fill_of(wp_next, rp_next);
    end

    // output slot handshake
    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                wp_reg <= wp_next;
                rp_reg <= rp_next;
            end
        end
    end

    // byte store write port
    always_ff @(posedge clk)
    begin
        if (take && do_write)
        begin
            mem[wp_reg] <= cmd.data;
        end
    end

    // result payload with registered store read
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg   <= do_pop ? mem[rp_reg] : 8'd0;
            rvalid_reg <= do_pop;
            fill_reg   <= 4'(fill_next);
            status_reg <= status_next;
        end
    end

    assign read_data    = data_reg;
    assign read_valid   = rvalid_reg;
    assign fill_count   = fill_reg;
    assign frame_status = status_reg;
    assign out_valid    = out_valid_reg;

    `ASSERT_ALWAYS(a_fill_bound, fill_cur < DEPTH_W, "buffer fill reached depth")
    `ASSERT_ALWAYS(a_no_write_full, !(take && do_write) || fill_cur < FILL_MAX,
        "byte written into a full buffer")
    `ASSERT_NEXT(a_pop_nonempty, take && do_pop, rvalid_reg && out_valid_reg,
        "popped byte not presented")

endmodule

`default_nettype wire

// ===== sv/ps2_frame_receiver_fifo_unit.sv =====
// path: accepted requests pass the request queue, then the buffer side's output register
// throughput: one request per cycle while m_tready stays high; the two-entry request
//   queue and the output register let the frame side and the buffer side stall apart
// reset: rst_n is asynchronous and active low; frame state, timer, pointers and
//   handshakes clear at once and idle_timeout returns to 100; byte store is not cleared
`timescale 1ns / 1ps
`default_nettype none

module ps2_frame_receiver_fifo_unit #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: idle_timeout
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] data_bit, [7:1] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [7:0] read_data, [8] read_valid,
                                        // [12:9] fill_count, [15:13] frame_status
);

    logic [15:0] idle_timeout_reg;

    ps2fr_pkg::cmd_t front_cmd;
    ps2fr_pkg::cmd_t back_cmd;
    logic            q_ready;
    logic            q_valid;
    logic            q_pop;
    logic            accept;

    logic [7:0] read_data;
    logic       read_valid;
    logic [3:0] fill_count;
    logic [2:0] frame_status;

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= ps2fr_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            idle_timeout_reg <= cfg_wdata;
        end
    end

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;

    // frame assembly and event classification
    ps2fr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (accept),
        .kind         (s_tuser),
        .data_bit     (s_tdata[0]),
        .idle_timeout (idle_timeout_reg),
        .cmd          (front_cmd)
    );

    // request queue between the two sides
    ps2fr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (back_cmd)
    );

    // byte buffer and result register
    ps2fr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd          (back_cmd),
        .cmd_pop      (q_pop),
        .read_data    (read_data),
        .read_valid   (read_valid),
        .fill_count   (fill_count),
        .frame_status (frame_status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready)
    );

    assign m_tdata = {frame_status, fill_count, read_valid, read_data};

endmodule

`default_nettype wire
